### hdl/npks_pkg.sv
// Shared types, codes and field layout for the nearest portal top-k select block.
package npks_pkg;

  // Field widths fixed by the stream payload.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned DOOR_W     = 16;
  localparam int unsigned FIELD_W    = 20;
  localparam int unsigned MAXCNT_W   = 7;
  localparam int unsigned PATH_W     = 22;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 4;

  // Bit offsets of the input fields inside tdata.
  localparam int unsigned OFS_DOOR   = 0;
  localparam int unsigned OFS_PORTAL = 16;
  localparam int unsigned OFS_START  = 76;
  localparam int unsigned OFS_END    = 136;
  localparam int unsigned OFS_MAXCNT = 196;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REG   = 2'd0,
    ACT_UNREG = 2'd1,
    ACT_QUERY = 2'd2
  } act_e;

  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN,
    OP_RD,
    OP_FINISH,
    OP_EMIT_NONE,
    OP_DIFF,
    OP_MUL,
    OP_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_HOLD_A,
    OP_LEN_WR,
    OP_SEL_CLR,
    OP_SEL_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
    logic       leg;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                cur_used;
    logic                out_free;
    logic                sqrt_done;
    logic                count_zero;
    logic                k_last;
  } stat_t;

endpackage

### hdl/npks_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/npks_ctrl.sv
// Controller state machine that sequences table scans, distance work and selection.
module npks_ctrl #(
  parameter int unsigned MAX_DOORS = 64,
  localparam int unsigned IDX_W = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  npks_pkg::stat_t     stat_i,
  output npks_pkg::cmd_t      cmd_o,
  output logic [IDX_W-1:0]    idx_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_SCAN, ST_DRAIN, ST_FINISH, ST_NONE, ST_QRD, ST_QDIFF,
    ST_QMUL, ST_QADD, ST_QSQI, ST_QSQS, ST_SELST, ST_SELEM
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       axis_q, axis_d;
  logic             leg_q, leg_d;
  logic             idx_last;

  assign idx_last = (idx_q == IDX_W'(MAX_DOORS - 1));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    axis_d     = axis_q;
    leg_d      = leg_q;
    cmd_o.op   = npks_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    cmd_o.leg  = leg_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.op = npks_pkg::OP_LATCH;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat_i.action)
          npks_pkg::ACT_REG, npks_pkg::ACT_UNREG: begin
            idx_d   = '0;
            state_d = ST_SCAN;
          end
          npks_pkg::ACT_QUERY: begin
            idx_d   = '0;
            state_d = stat_i.count_zero ? ST_NONE : ST_QRD;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd_o.op = npks_pkg::OP_SCAN;
        if (idx_last) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // The last read of the scan is compared in this cycle.
        state_d = (stat_i.action == npks_pkg::ACT_QUERY) ? ST_SELEM : ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = npks_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      ST_NONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = npks_pkg::OP_EMIT_NONE;
          state_d  = ST_IDLE;
        end
      end
      ST_QRD: begin
        if (stat_i.cur_used) begin
          cmd_o.op = npks_pkg::OP_RD;
          axis_d   = '0;
          leg_d    = 1'b0;
          state_d  = ST_QDIFF;
        end else if (idx_last) begin
          state_d = ST_SELST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_QDIFF: begin
        cmd_o.op = npks_pkg::OP_DIFF;
        state_d  = ST_QMUL;
      end
      ST_QMUL: begin
        cmd_o.op = npks_pkg::OP_MUL;
        state_d  = ST_QADD;
      end
      ST_QADD: begin
        cmd_o.op = npks_pkg::OP_ACC;
        if (axis_q == 2'd2) begin
          state_d = ST_QSQI;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = ST_QDIFF;
        end
      end
      ST_QSQI: begin
        cmd_o.op = npks_pkg::OP_SQRT_INIT;
        state_d  = ST_QSQS;
      end
      ST_QSQS: begin
        if (!stat_i.sqrt_done) begin
          cmd_o.op = npks_pkg::OP_SQRT_STEP;
        end else if (!leg_q) begin
          cmd_o.op = npks_pkg::OP_HOLD_A;
          leg_d    = 1'b1;
          axis_d   = '0;
          state_d  = ST_QDIFF;
        end else begin
          cmd_o.op = npks_pkg::OP_LEN_WR;
          if (idx_last) begin
            state_d = ST_SELST;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_QRD;
          end
        end
      end
      ST_SELST: begin
        cmd_o.op = npks_pkg::OP_SEL_CLR;
        idx_d    = '0;
        state_d  = ST_SCAN;
      end
      ST_SELEM: begin
        if (stat_i.out_free) begin
          cmd_o.op = npks_pkg::OP_SEL_EMIT;
          state_d  = stat_i.k_last ? ST_IDLE : ST_SELST;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      axis_q  <= '0;
      leg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      axis_q  <= axis_d;
      leg_q   <= leg_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign idx_o      = idx_q;

endmodule

### hdl/npks_dp.sv
// Datapath: door table, distance arithmetic, iterative square root and selection.
module npks_dp #(
  parameter int unsigned MAX_DOORS  = 64,
  parameter int unsigned COORD_BITS = 20,
  localparam int unsigned IDX_W = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [npks_pkg::IN_TDATA_W-1:0]       s_tdata_i,
  input  logic [npks_pkg::ACTION_W-1:0]         s_tuser_i,
  input  npks_pkg::cmd_t                        cmd_i,
  input  logic [IDX_W-1:0]                      idx_i,
  output npks_pkg::stat_t                       stat_o,
  input  logic                                  m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [npks_pkg::OUT_TDATA_W-1:0]      m_tdata_o,
  output logic [npks_pkg::OUT_TUSER_W-1:0]      m_tuser_o,
  output logic                                  m_tlast_o
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned PT_W   = 3 * C;
  localparam int unsigned DW     = npks_pkg::DOOR_W;
  localparam int unsigned SLOT_W = DW + PT_W;
  localparam int unsigned RT_W   = C + 1;
  localparam int unsigned SQ_W   = 2 * RT_W;
  localparam int unsigned LEN_W  = C + 2;
  localparam int unsigned CNT_W  = $clog2(MAX_DOORS + 1);

  // Latched transaction.
  logic [npks_pkg::ACTION_W-1:0] act_q;
  logic [DW-1:0]                 id_q;
  logic [PT_W-1:0]               pin_q, start_q, end_q;
  logic [CNT_W-1:0]              cnt_q, k_q, n_q;

  logic [MAX_DOORS-1:0] used_q, taken_q;
  logic                 found_q, free_vld_q, cmp_pend_q;
  logic [IDX_W-1:0]     found_idx_q, free_idx_q, rd_idx_q;

  logic             best_vld_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [LEN_W-1:0] best_len_q;
  logic [DW-1:0]    best_id_q;

  logic [RT_W-1:0] absd_q, root_a_q;
  logic [SQ_W-1:0] prod_q, acc_q, sq_n_q, sq_res_q, sq_bit_q;

  logic                          out_vld_q, out_valres_q, out_last_q;
  logic [DW-1:0]                 out_id_q;
  logic [LEN_W-1:0]              out_len_q;
  logic [npks_pkg::STATUS_W-1:0] out_status_q;

  logic [SLOT_W-1:0] slot_rd;
  logic [LEN_W-1:0]  len_rd;
  logic [DW-1:0]     rd_door;
  logic [PT_W-1:0]   rd_pt;
  logic              slot_we, len_we, ram_re;
  logic [LEN_W-1:0]  len_wdata;

  logic [C-1:0]        coord_a, coord_b;
  logic signed [C:0]   diff;
  logic [RT_W-1:0]     absd;
  logic [SQ_W-1:0]     sq_sum;
  logic                out_free;
  logic                cand, better, rd_used;
  logic [7:0]          maxc_ext, n_ext;

  assign rd_door = slot_rd[DW-1:0];
  assign rd_pt   = slot_rd[SLOT_W-1:DW];
  assign ram_re  = (cmd_i.op == npks_pkg::OP_RD) || (cmd_i.op == npks_pkg::OP_SCAN);
  assign slot_we = (cmd_i.op == npks_pkg::OP_FINISH) && (act_q == npks_pkg::ACT_REG) &&
                   !found_q && free_vld_q;
  assign len_we    = (cmd_i.op == npks_pkg::OP_LEN_WR);
  assign len_wdata = LEN_W'(root_a_q) + LEN_W'(sq_res_q[RT_W-1:0]);

  npks_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_DOORS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (free_idx_q),
    .wdata_i ({pin_q, id_q}),
    .re_i    (ram_re),
    .raddr_i (idx_i),
    .rdata_o (slot_rd)
  );

  npks_ram #(.WIDTH(LEN_W), .DEPTH(MAX_DOORS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (idx_i),
    .wdata_i (len_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_i),
    .rdata_o (len_rd)
  );

  // One axis of one leg: the query endpoint against the stored portal point.
  assign coord_a = cmd_i.leg ? end_q[int'(cmd_i.axis) * C +: C]
                             : start_q[int'(cmd_i.axis) * C +: C];
  assign coord_b = rd_pt[int'(cmd_i.axis) * C +: C];
  assign diff    = $signed({coord_a[C-1], coord_a}) - $signed({coord_b[C-1], coord_b});
  assign absd    = diff[C] ? RT_W'(-diff) : RT_W'(diff);
  assign sq_sum  = sq_res_q + sq_bit_q;

  assign rd_used = used_q[rd_idx_q];
  assign cand    = cmp_pend_q && rd_used && !taken_q[rd_idx_q];
  assign better  = !best_vld_q || (len_rd < best_len_q) ||
                   ((len_rd == best_len_q) && (rd_door < best_id_q));

  assign out_free = !out_vld_q || m_tready_i;
  assign maxc_ext = 8'(s_tdata_i[npks_pkg::OFS_MAXCNT +: npks_pkg::MAXCNT_W]);
  assign n_ext    = 8'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      n_q        <= '0;
      out_vld_q  <= 1'b0;
      cmp_pend_q <= 1'b0;
    end else begin
      cmp_pend_q <= (cmd_i.op == npks_pkg::OP_SCAN);
      if ((cmd_i.op == npks_pkg::OP_FINISH) || (cmd_i.op == npks_pkg::OP_EMIT_NONE) ||
          (cmd_i.op == npks_pkg::OP_SEL_EMIT)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.op == npks_pkg::OP_FINISH) begin
        if (act_q == npks_pkg::ACT_REG) begin
          if (!found_q && free_vld_q) begin
            used_q[free_idx_q] <= 1'b1;
            n_q                <= n_q + 1'b1;
          end
        end else if (found_q) begin
          used_q[found_idx_q] <= 1'b0;
          n_q                 <= n_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_i;
    case (cmd_i.op)
      npks_pkg::OP_LATCH: begin
        act_q      <= s_tuser_i;
        id_q       <= s_tdata_i[npks_pkg::OFS_DOOR +: DW];
        for (int a = 0; a < 3; a++) begin
          pin_q[a*C +: C]   <= s_tdata_i[npks_pkg::OFS_PORTAL + a*npks_pkg::FIELD_W +: C];
          start_q[a*C +: C] <= s_tdata_i[npks_pkg::OFS_START + a*npks_pkg::FIELD_W +: C];
          end_q[a*C +: C]   <= s_tdata_i[npks_pkg::OFS_END + a*npks_pkg::FIELD_W +: C];
        end
        cnt_q      <= (maxc_ext < n_ext) ? CNT_W'(maxc_ext) : n_q;
        k_q        <= '0;
        taken_q    <= '0;
        found_q    <= 1'b0;
        free_vld_q <= 1'b0;
      end
      npks_pkg::OP_DIFF:      absd_q <= absd;
      npks_pkg::OP_MUL:       prod_q <= absd_q * absd_q;
      npks_pkg::OP_ACC:       acc_q  <= ((cmd_i.axis == 2'd0) ? '0 : acc_q) + prod_q;
      npks_pkg::OP_SQRT_INIT: begin
        sq_n_q   <= acc_q;
        sq_res_q <= '0;
        sq_bit_q <= SQ_W'(1) << (2 * C);
      end
      npks_pkg::OP_SQRT_STEP: begin
        // One result bit per step, the classic restoring digit recurrence.
        if (sq_n_q >= sq_sum) begin
          sq_n_q   <= sq_n_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      npks_pkg::OP_HOLD_A:  root_a_q   <= sq_res_q[RT_W-1:0];
      npks_pkg::OP_SEL_CLR: best_vld_q <= 1'b0;
      npks_pkg::OP_FINISH: begin
        out_id_q     <= '0;
        out_len_q    <= '0;
        out_valres_q <= 1'b0;
        out_last_q   <= 1'b1;
        if (act_q == npks_pkg::ACT_REG) begin
          out_status_q <= found_q ? npks_pkg::STAT_DUP :
                          (free_vld_q ? npks_pkg::STAT_OK : npks_pkg::STAT_FULL);
        end else begin
          out_status_q <= found_q ? npks_pkg::STAT_OK : npks_pkg::STAT_NOTFOUND;
        end
      end
      npks_pkg::OP_EMIT_NONE: begin
        out_id_q     <= '0;
        out_len_q    <= '0;
        out_valres_q <= 1'b0;
        out_last_q   <= 1'b1;
        out_status_q <= npks_pkg::STAT_NONE;
      end
      npks_pkg::OP_SEL_EMIT: begin
        out_id_q             <= best_id_q;
        out_len_q            <= best_len_q;
        out_valres_q         <= 1'b1;
        out_last_q           <= (k_q == CNT_W'(cnt_q - 1'b1));
        out_status_q         <= npks_pkg::STAT_OK;
        taken_q[best_idx_q]  <= 1'b1;
        k_q                  <= k_q + 1'b1;
      end
      default: ;
    endcase
    // Compare stage of a scan, in the cycle after the read it belongs to.
    if (cmp_pend_q) begin
      if (act_q == npks_pkg::ACT_QUERY) begin
        if (cand && better) begin
          best_vld_q <= 1'b1;
          best_idx_q <= rd_idx_q;
          best_len_q <= len_rd;
          best_id_q  <= rd_door;
        end
      end else begin
        if (rd_used && (rd_door == id_q) && !found_q) begin
          found_q     <= 1'b1;
          found_idx_q <= rd_idx_q;
        end
        if (!rd_used && !free_vld_q) begin
          free_vld_q <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
      end
    end
  end

  assign stat_o.action     = act_q;
  assign stat_o.cur_used   = used_q[idx_i];
  assign stat_o.out_free   = out_free;
  assign stat_o.sqrt_done  = (sq_bit_q == '0);
  assign stat_o.count_zero = (cnt_q == '0);
  assign stat_o.k_last     = (k_q == CNT_W'(cnt_q - 1'b1));

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {2'b00, npks_pkg::PATH_W'(out_len_q), out_id_q};
  assign m_tuser_o  = {out_valres_q, out_status_q};
  assign m_tlast_o  = out_last_q;

endmodule

### hdl/nearest_portal_top_k_select_core.sv
// Top level of the nearest portal top-k select block.
// Input stream: tuser carries the action (register, unregister, query) and tdata
// the door id, portal point, query start and end points and max_count. One
// transaction is taken at a time; tready is high only while the block is idle.
// Register and unregister scan the whole table, then give one status result.
// A query works out each stored door's path length with one multiplier and a
// bit-serial square root, then picks each result by a full pass over the
// table, in ascending length with the lower id first on ties. The last
// result carries tlast; an empty query gives one result with status four.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed. Results sit in one output register: a stalled receiver holds
// the block in its current step until the register is free, losing nothing.
module nearest_portal_top_k_select_core #(
  parameter int unsigned MAX_DOORS  = 64,
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: door_id, portal_x, portal_y, portal_z, start_x, start_y, start_z,
  // end_x, end_y, end_z, max_count, zero padding
  input  logic [npks_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: action
  input  logic [npks_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: result_id, path_length, zero padding
  output logic [npks_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: status, valid_res
  output logic [npks_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned IDX_W = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1;

  npks_pkg::cmd_t   cmd;
  npks_pkg::stat_t  stat;
  logic [IDX_W-1:0] idx;

  npks_ctrl #(.MAX_DOORS(MAX_DOORS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  npks_dp #(.MAX_DOORS(MAX_DOORS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .stat_o     (stat),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // A status-only result carries no id and no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[3]) |-> (m_axis_tdata[37:0] == '0))
    else $error("status result carries candidate data");

  // A status-only result always closes its transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[3]) |-> m_axis_tlast)
    else $error("status result without tlast");

  // The block is busy in the cycle after it takes a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

endmodule
